// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cobs_fd_pkg.sv
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package cobs_fd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned CountW = 16;

   localparam logic [ByteW-1:0]  CodeFull    = 8'd255;
   localparam logic [CountW-1:0] CapReset    = 16'd4096;

   typedef struct packed {
      logic [ByteW-1:0]  bytes_left;
      logic              block_full;
      logic [CountW-1:0] decoded_count;
      logic              frame_bad;
      logic              at_frame_start;
   } frame_state_type;

   localparam frame_state_type FrameClear = '{
      bytes_left:     '0,
      block_full:     1'b0,
      decoded_count:  '0,
      frame_bad:      1'b0,
      at_frame_start: 1'b1
   };

   typedef struct packed {
      logic [ByteW-1:0]  out_byte;
      logic              byte_valid;
      logic              frame_end;
      logic              frame_ok;
      logic [CountW-1:0] frame_length;
   } rsp_payload_type;

endpackage

// File: design/cobs_fd_if.sv
// ----------------------------------------------------------------------------
// COBS frame decoder channel interfaces
// Valid/ready request channel (encoded bytes) and result channel.
// ----------------------------------------------------------------------------
interface cobs_fd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface cobs_fd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        frame_end;
   logic        frame_ok;
   logic [15:0] frame_length;

   modport source (output valid, output out_byte, output byte_valid, output frame_end,
                   output frame_ok, output frame_length, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                   input frame_ok, input frame_length, output ready);
endinterface

// File: design/cobs_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// COBS frame decoder unit
// Decodes a COBS stream, one encoded byte per request, with frame status.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Carries
//  req_if   in   valid/ready        in_byte, last_byte
//  rsp_if   out  valid/ready        out_byte, byte_valid, frame_end, frame_ok,
//                                   frame_length
//  csr_*    in   write enable only  out_capacity (16 bits, reset 4096)
//
//  One request per cycle sustained unless a stalled result blocks it; an
//  accepted request passes the input register, then the result register.
//  The step logic between the input register and the frame state is
//  combinational, so frame state is always current for the next byte.
//  Requests giving no result (code bytes owing no zero, non-last bytes after
//  an error) retire without touching the result register.
//  A stalled result blocks only a request that would give another result.
//  Reset (synchronous) clears frame state and sets the capacity to 4096.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_unit (
   input  logic                 clock,
   input  logic                 reset,
   cobs_fd_req_if.sink          req_if,
   cobs_fd_rsp_if.source        rsp_if,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);
   import cobs_fd_pkg::*;

   // capacity register
   logic [15:0]     cap_ff;

   // input register
   logic            s1_valid_ff;
   logic [7:0]      s1_byte_ff;
   logic            s1_last_ff;

   // frame state
   frame_state_type state_ff;
   frame_state_type state_in;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   logic            has_result;
   logic            out_free;
   logic            s1_fire;
   logic            req_fire;

   cobs_fd_core u_core (
      .cur_state  (state_ff),
      .in_byte    (s1_byte_ff),
      .last_byte  (s1_last_ff),
      .capacity   (cap_ff),
      .next_state (state_in),
      .result     (rsp_payload_in),
      .has_result (has_result)
   );

   // the held byte retires when its result, if any, has room
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire  = s1_valid_ff && (!has_result || out_free);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_if.in_byte;
         s1_last_ff <= req_if.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrameClear;
      end else if (s1_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_fire && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_result) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_byte     = rsp_payload_ff.out_byte;
   assign rsp_if.byte_valid   = rsp_payload_ff.byte_valid;
   assign rsp_if.frame_end    = rsp_payload_ff.frame_end;
   assign rsp_if.frame_ok     = rsp_payload_ff.frame_ok;
   assign rsp_if.frame_length = rsp_payload_ff.frame_length;

endmodule

// File: design/cobs_fd_core.sv
// ----------------------------------------------------------------------------
// COBS frame decoder step logic
// Next frame state and result for one encoded byte.
// ----------------------------------------------------------------------------
module cobs_fd_core (
   input  cobs_fd_pkg::frame_state_type cur_state,
   input  logic [7:0]                   in_byte,
   input  logic                         last_byte,
   input  logic [15:0]                  capacity,
   output cobs_fd_pkg::frame_state_type next_state,
   output cobs_fd_pkg::rsp_payload_type result,
   output logic                         has_result
);
   import cobs_fd_pkg::*;

   frame_state_type upd;
   logic [17:0]     need_sum;
   logic [17:0]     cap_lim;

   assign cap_lim  = {2'b00, capacity} + 18'd1;

   always_comb begin
      upd                 = cur_state;
      result              = '0;
      need_sum            = '0;
      if (!cur_state.frame_bad) begin
         if (cur_state.bytes_left == '0) begin
            // code byte; a short previous block owes a zero
            if (!cur_state.at_frame_start && !cur_state.block_full) begin
               if (cur_state.decoded_count >= capacity) begin
                  upd.frame_bad = 1'b1;
               end else begin
                  result.byte_valid = 1'b1;
                  upd.decoded_count = cur_state.decoded_count + 16'd1;
               end
            end
            upd.at_frame_start = 1'b0;
            // block fits when count + code - 1 <= capacity
            need_sum = {2'b00, upd.decoded_count} + {10'd0, in_byte};
            if (!upd.frame_bad) begin
               if (in_byte == '0) begin
                  upd.frame_bad = 1'b1;
               end else if (need_sum > cap_lim) begin
                  upd.frame_bad = 1'b1;
               end else begin
                  upd.bytes_left = in_byte - 8'd1;
                  upd.block_full = (in_byte == CodeFull);
               end
            end
         end else begin
            // data byte
            if (in_byte == '0) begin
               upd.frame_bad = 1'b1;
            end else begin
               result.byte_valid = 1'b1;
               result.out_byte   = in_byte;
               upd.decoded_count = cur_state.decoded_count + 16'd1;
               upd.bytes_left    = cur_state.bytes_left - 8'd1;
            end
         end
         if (last_byte && !upd.frame_bad && upd.bytes_left != '0) begin
            upd.frame_bad = 1'b1;
         end
      end
      result.frame_end    = last_byte;
      result.frame_ok     = last_byte && !upd.frame_bad;
      result.frame_length = result.frame_ok ? upd.decoded_count : '0;
   end

   assign has_result = result.byte_valid || last_byte;
   assign next_state = last_byte ? FrameClear : upd;

endmodule

// File: design/cobs_fd_checker.sv
// ----------------------------------------------------------------------------
// COBS frame decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cobs_fd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic        byte_valid,
   input logic        frame_end,
   input logic        frame_ok,
   input logic [15:0] frame_length
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({out_byte, byte_valid, frame_end, frame_ok, frame_length}), "result changed while stalled")
   `ASSERT_IMPLY(a_rsp_nonempty, clock, reset, rsp_valid, byte_valid || frame_end, "empty result")
   `ASSERT_IMPLY(a_mid_frame_quiet, clock, reset, rsp_valid && !frame_end, !frame_ok && frame_length == 16'd0, "status outside frame end")
   `ASSERT_IMPLY(a_bad_len_zero, clock, reset, rsp_valid && frame_end && !frame_ok, frame_length == 16'd0, "length on failed frame")
   `ASSERT_IMPLY(a_no_byte_zero, clock, reset, rsp_valid && !byte_valid, out_byte == 8'd0, "stray byte value")

endmodule

bind cobs_frame_decoder_unit cobs_fd_checker u_cobs_fd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .out_byte     (rsp_if.out_byte),
   .byte_valid   (rsp_if.byte_valid),
   .frame_end    (rsp_if.frame_end),
   .frame_ok     (rsp_if.frame_ok),
   .frame_length (rsp_if.frame_length)
);
